### src/bdtw_pkg.sv
// Shared constants, codes and types of the banded DTW distance block.
`default_nettype none

package bdtw_pkg;

    // Size of the reference store and the longest query.
    localparam int MAX_REF_LEN   = 256;
    localparam int MAX_QUERY_LEN = 4096;

    // Derived widths.
    localparam int REF_AW = $clog2(MAX_REF_LEN);
    localparam int COL_W  = $clog2(MAX_REF_LEN + 1);
    localparam int QPOS_W = $clog2(MAX_QUERY_LEN + 1);

    // Field widths.
    localparam int SAMPLE_W   = 16;
    localparam int INDEX_W    = 8;
    localparam int LEN_W      = 9;
    localparam int BAND_W     = 13;
    localparam int DIST_W     = 31;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Width of the band window sums (column plus half width, row plus half width).
    localparam int BAND_SUM_W = ((QPOS_W > BAND_W) ? QPOS_W : BAND_W) + 1;

    // Saturating cost value that marks an unreachable cell.
    localparam logic [DIST_W-1:0] COST_SENTINEL = '1;

    // Item function codes.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERLONG = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REF_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_WIDTH = 1'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load_we;
        logic                query;
        logic                issue;
        logic [COL_W-1:0]    col;
        logic [QPOS_W-1:0]   row;
        logic                emit;
        logic [STATUS_W-1:0] status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic len_zero;
    } t_dp_status;

endpackage

`default_nettype wire

### src/bdtw_if.sv
// Handshake channel interfaces of the banded DTW distance block.
`default_nettype none

interface bdtw_in_if import bdtw_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample;
    logic [INDEX_W-1:0]         ref_index;
    logic                       last;

    modport source (output valid, output func, output sample, output ref_index,
                    output last, input ready);
    modport sink   (input valid, input func, input sample, input ref_index,
                    input last, output ready);
endinterface

interface bdtw_out_if import bdtw_pkg::*;;
    logic                valid;
    logic                ready;
    logic [DIST_W-1:0]   distance;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output distance, output status, input ready);
    modport sink   (input valid, input distance, input status, output ready);
endinterface

interface bdtw_cfg_if import bdtw_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/bdtw_ctrl.sv
// Controller of the banded DTW distance block: item sequencing and row sweep.
`default_nettype none

module bdtw_ctrl import bdtw_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_func,
    input  wire logic       i_in_last,
    output logic            o_in_ready,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SWEEP  = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]        r_state,     n_state;
    logic [COL_W-1:0]  r_col,       n_col;
    logic              r_drain,     n_drain;
    logic [QPOS_W-1:0] r_qpos,      n_qpos;
    logic              r_overlong,  n_overlong;
    logic              r_last,      n_last;
    logic              r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_drain    = r_drain;
        n_qpos     = r_qpos;
        n_overlong = r_overlong;
        n_last     = r_last;
        o_cmd      = '0;
        o_cmd.col  = r_col;
        o_cmd.row  = r_qpos;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_func == FUNC_LOAD) begin
                        o_cmd.load_we = 1'b1;
                    end else begin
                        o_cmd.query = 1'b1;
                        n_last      = i_in_last;
                        if (r_qpos >= QPOS_W'(MAX_QUERY_LEN)) begin
                            // The row is left as it is; only the flag records the sample.
                            n_overlong = 1'b1;
                            if (i_in_last) begin
                                n_state = S_FINISH;
                            end
                        end else begin
                            n_qpos    = r_qpos + QPOS_W'(1);
                            o_cmd.row = n_qpos;
                            n_col     = COL_W'(1);
                            n_state   = S_SWEEP;
                        end
                    end
                end
            end
            S_SWEEP: begin
                o_cmd.issue = 1'b1;
                if (r_col == COL_W'(MAX_REF_LEN)) begin
                    n_drain = 1'b0;
                    n_state = S_DRAIN;
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
            S_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = r_last ? S_FINISH : S_IDLE;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.len_zero) begin
                        o_cmd.status = ST_EMPTY;
                    end else if (r_overlong) begin
                        o_cmd.status = ST_OVERLONG;
                    end else begin
                        o_cmd.status = ST_OK;
                    end
                    n_qpos     = '0;
                    n_overlong = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = o_cmd.emit | (r_out_valid & ~i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_drain     <= 1'b0;
            r_qpos      <= '0;
            r_overlong  <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_drain     <= n_drain;
            r_qpos      <= n_qpos;
            r_overlong  <= n_overlong;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### src/bdtw_dp.sv
// Datapath of the banded DTW distance block: stores, cell pipeline and result register.
`default_nettype none

module bdtw_dp import bdtw_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic signed [SAMPLE_W-1:0] i_in_sample,
    input  wire logic [INDEX_W-1:0]         i_in_ref_index,
    input  wire t_dp_cmd                    i_cmd,
    output t_dp_status                      o_status,
    output logic [DIST_W-1:0]               o_distance,
    output logic [STATUS_W-1:0]             o_result_status
);

    // Configuration registers.
    logic [LEN_W-1:0]  r_ref_length;
    logic [BAND_W-1:0] r_band_width;

    // Values held for the current query item.
    logic signed [SAMPLE_W-1:0] r_q;
    logic [COL_W-1:0]           r_len;
    logic [BAND_W-1:0]          r_band;
    logic [QPOS_W-1:0]          r_row;

    // Stores: reference samples and cost row columns 1 and up.
    logic [SAMPLE_W-1:0] ref_mem  [MAX_REF_LEN];
    logic [DIST_W-1:0]   cost_mem [MAX_REF_LEN];
    logic [SAMPLE_W-1:0] r_ref_rd;
    logic [DIST_W-1:0]   r_cost_rd;

    // Pipeline registers.
    logic                r_a_valid;
    logic [COL_W-1:0]    r_a_col;
    logic                r_b_valid;
    logic [COL_W-1:0]    r_b_col;
    logic [DIST_W-1:0]   r_b_mu;
    logic [SAMPLE_W-1:0] r_b_d;
    logic                r_b_inband;
    logic [DIST_W-1:0]   r_prev_up;
    logic [DIST_W-1:0]   r_left;
    logic [DIST_W-1:0]   r_final;

    logic [DIST_W-1:0]   r_out_distance;
    logic [STATUS_W-1:0] r_out_status;

    logic [REF_AW-1:0]     rd_addr;
    logic                  first_row;
    logic [DIST_W-1:0]     b_up;
    logic [DIST_W-1:0]     b_col0;
    logic [DIST_W-1:0]     b_upleft;
    logic [DIST_W-1:0]     b_mu;
    logic [SAMPLE_W:0]     b_diff;
    logic [SAMPLE_W:0]     b_abs;
    logic                  b_in_len;
    logic                  b_in_band;
    logic [BAND_SUM_W-1:0] b_col_ext;
    logic [BAND_SUM_W-1:0] b_row_ext;
    logic [BAND_SUM_W-1:0] b_band_ext;
    logic [DIST_W-1:0]     c_left;
    logic [DIST_W-1:0]     c_min;
    logic [DIST_W:0]       c_sum;
    logic [DIST_W-1:0]     c_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_length <= '0;
            r_band_width <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REF_LENGTH: r_ref_length <= i_cfg_data[LEN_W-1:0];
                CFG_BAND_WIDTH: r_band_width <= i_cfg_data[BAND_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_q    <= i_in_sample;
            r_band <= r_band_width;
            r_row  <= i_cmd.row;
            if (int'(r_ref_length) > MAX_REF_LEN) begin
                r_len <= COL_W'(MAX_REF_LEN);
            end else begin
                r_len <= COL_W'(r_ref_length);
            end
        end
    end

    assign rd_addr = REF_AW'(i_cmd.col - COL_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && (int'(i_in_ref_index) < MAX_REF_LEN)) begin
            ref_mem[REF_AW'(i_in_ref_index)] <= i_in_sample;
        end
        if (i_cmd.issue) begin
            r_ref_rd <= ref_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            cost_mem[REF_AW'(r_b_col - COL_W'(1))] <= c_cell;
        end
        if (i_cmd.issue) begin
            r_cost_rd <= cost_mem[rd_addr];
        end
    end

    // Stage B: neighbors from the previous row, local distance and window test.
    // Before the first row of a query the kept row is all sentinel except column zero.
    assign first_row = (r_row == QPOS_W'(1));
    assign b_up      = first_row ? COST_SENTINEL : r_cost_rd;
    assign b_col0    = first_row ? '0 : COST_SENTINEL;
    assign b_upleft  = (r_a_col == COL_W'(1)) ? b_col0 : r_prev_up;
    assign b_mu      = (b_up < b_upleft) ? b_up : b_upleft;
    assign b_diff    = {r_q[SAMPLE_W-1], r_q} - {r_ref_rd[SAMPLE_W-1], r_ref_rd};
    assign b_abs     = b_diff[SAMPLE_W] ? (~b_diff + (SAMPLE_W+1)'(1)) : b_diff;

    assign b_col_ext  = BAND_SUM_W'(r_a_col);
    assign b_row_ext  = BAND_SUM_W'(r_row);
    assign b_band_ext = BAND_SUM_W'(r_band);
    assign b_in_len   = (r_a_col <= r_len);
    assign b_in_band  = (r_band == '0) ||
                        ((b_col_ext + b_band_ext >= b_row_ext) &&
                         (b_col_ext <= b_row_ext + b_band_ext));

    // Stage C: smallest neighbor plus local distance, saturating at the sentinel.
    assign c_left = (r_b_col == COL_W'(1)) ? COST_SENTINEL : r_left;
    assign c_min  = (r_b_mu < c_left) ? r_b_mu : c_left;
    assign c_sum  = {1'b0, c_min} + (DIST_W+1)'(r_b_d);

    always_comb begin
        if (!r_b_inband || (c_min == COST_SENTINEL) || c_sum[DIST_W]) begin
            c_cell = COST_SENTINEL;
        end else begin
            c_cell = c_sum[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_cmd.issue;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_a_col <= i_cmd.col;
        end
        if (r_a_valid) begin
            r_b_col    <= r_a_col;
            r_b_mu     <= b_mu;
            r_b_d      <= b_abs[SAMPLE_W-1:0];
            r_b_inband <= b_in_len && b_in_band;
            r_prev_up  <= b_up;
        end
        if (r_b_valid) begin
            r_left <= c_cell;
            if (r_b_col == r_len) begin
                r_final <= c_cell;
            end
        end
        if (i_cmd.emit) begin
            r_out_distance <= (i_cmd.status == ST_OK) ? r_final : COST_SENTINEL;
            r_out_status   <= i_cmd.status;
        end
    end

    assign o_status.len_zero = (r_len == '0);
    assign o_distance        = r_out_distance;
    assign o_result_status   = r_out_status;

endmodule

`default_nettype wire

### src/banded_dtw_distance.sv
// Top level of the banded dynamic time warping distance block.
//
// Usage: a reference sequence is loaded by input beats with func set to load,
// each writing one sample at ref_index; a query is then streamed as beats with
// func set to query, the final one carrying last. Each query beat computes one
// new row of accumulated costs over all reference columns, limited to the
// Sakoe-Chiba window when band_width is non-zero. The beat with last set
// produces one output beat with the distance of the final cell and a status.
// The configuration channel writes ref_length (index 0) and band_width
// (index 1); it is always ready and is meant to be written while idle.
//
// Timing: a load beat keeps the block idle. A query beat is accepted, then the
// row sweep visits one column per cycle through the cost row memory and the
// cell pipeline empties before the next beat is taken. After a last beat the
// result register loads once the output register is free. A query beat past
// the maximum query length only sets a flag. Reset clears the control and
// configuration registers, the query position and the error flag; the
// reference store is undefined until written. When the receiver stalls, the
// result waits in the output register while the next query is processed.
`default_nettype none

module banded_dtw_distance import bdtw_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    bdtw_in_if.sink    i_in,
    bdtw_out_if.source o_out,
    bdtw_cfg_if.sink   i_cfg
);

    t_dp_cmd    cmd;
    t_dp_status dp_status;

    // Configuration writes never stall.
    assign i_cfg.ready = 1'b1;

    bdtw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_func   (i_in.func),
        .i_in_last   (i_in.last),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (dp_status),
        .o_cmd       (cmd)
    );

    bdtw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_in_sample     (i_in.sample),
        .i_in_ref_index  (i_in.ref_index),
        .i_cmd           (cmd),
        .o_status        (dp_status),
        .o_distance      (o_out.distance),
        .o_result_status (o_out.status)
    );

endmodule

`default_nettype wire

### src/bdtw_checker.sv
// Port-level checker of the banded DTW distance block and its bind.
`default_nettype none

module bdtw_checker import bdtw_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic                i_in_func,
    input wire logic                i_in_last,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic [DIST_W-1:0]   i_out_distance,
    input wire logic [STATUS_W-1:0] i_out_status
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_distance) && $stable(i_out_status))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_out_status == ST_OK || i_out_status == ST_EMPTY ||
             i_out_status == ST_OVERLONG))
        else $error("undefined result status");

    // Every error result carries the sentinel distance.
    a_error_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != ST_OK |-> i_out_distance == COST_SENTINEL)
        else $error("error result without sentinel distance");

    // A load beat finishes in its own cycle.
    a_load_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_func == FUNC_LOAD |=> i_in_ready)
        else $error("input not ready after a load beat");

    // The final query beat always holds off the input while its result forms.
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_func == FUNC_QUERY && i_in_last |=> !i_in_ready)
        else $error("input ready right after the final query beat");

endmodule

bind banded_dtw_distance bdtw_checker u_bdtw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_func      (i_in.func),
    .i_in_last      (i_in.last),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_distance (o_out.distance),
    .i_out_status   (o_out.status)
);

`default_nettype wire

### dv/tb_banded_dtw_distance.sv
// Self-checking testbench for the banded DTW distance block: directed table, random queries, scoreboard.
`timescale 1ns / 100ps

module tb_banded_dtw_distance;
    import bdtw_pkg::*;

    // Cycles a query beat may still spend in the row sweep and draining the
    // cell pipeline after the last result has come out.
    localparam int SETTLE_CYCLES = 300;

    // Random beats after the directed table, not counting the over-long query.
    localparam int RANDOM_BEATS = 1750;

    // The slowest correct run is dominated by the over-long query: about 4100
    // query beats, each with a full row sweep. Together with roughly 2000 other
    // beats, the sender gaps, the receiver stalls and the settling pauses before
    // each register write, this stays below 16 ms. The limit takes that more than
    // twice over.
    localparam int LIMIT_NS = 40_000_000;

    localparam logic [31:0] SENTINEL_32 = {1'b0, COST_SENTINEL};

    typedef struct packed {
        logic                       func;
        logic signed [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]         ref_index;
        logic                       last;
    } t_beat;

    typedef struct packed {
        logic [DIST_W-1:0]   distance;
        logic [STATUS_W-1:0] status;
    } t_result;

    typedef enum logic {ROW_CFG, ROW_BEAT} t_row_kind;

    // One row of the directed table. A register row writes both registers; a
    // beat row sends one input beat and, where typed is set, expects want
    // instead of what the predictor works out.
    typedef struct packed {
        t_row_kind             kind;
        t_beat                 beat;
        logic [CFG_DATA_W-1:0] len;
        logic [CFG_DATA_W-1:0] band;
        logic                  typed;
        t_result               want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    bdtw_in_if  beat_in ();
    bdtw_out_if result_out ();
    bdtw_cfg_if cfg_wr ();

    banded_dtw_distance uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (beat_in),
        .o_out   (result_out),
        .i_cfg   (cfg_wr)
    );

    // Directed table. The reference is loaded with the two sample extremes and
    // zero, then single-row queries give costs that can be read off directly:
    // a query of -32768 against 32767, -32768, 0 sums 65535, 0 and 32768 along
    // the top row. A band of one on a one-row query leaves the last of three
    // columns unreachable. A reference length of zero answers the empty status.
    t_row plan [21] = '{
        '{ROW_BEAT, '{FUNC_QUERY, 16'sh0000, 8'hFF, 1'b1}, 13'd0, 13'd0,
          1'b1, '{COST_SENTINEL, ST_EMPTY}},
        '{ROW_BEAT, '{FUNC_LOAD, 16'sh7FFF, 8'd0, 1'b0}, 13'd0, 13'd0, 1'b0, '0},
        '{ROW_BEAT, '{FUNC_LOAD, 16'sh8000, 8'd1, 1'b1}, 13'd0, 13'd0, 1'b0, '0},
        '{ROW_BEAT, '{FUNC_LOAD, 16'sh0000, 8'd2, 1'b0}, 13'd0, 13'd0, 1'b0, '0},
        '{ROW_BEAT, '{FUNC_LOAD, 16'shA5A5, 8'd255, 1'b0}, 13'd0, 13'd0, 1'b0, '0},
        '{ROW_CFG, '0, 13'd3, 13'd0, 1'b0, '0},
        '{ROW_BEAT, '{FUNC_QUERY, 16'sh8000, 8'h00, 1'b1}, 13'd0, 13'd0,
          1'b1, '{31'd98303, ST_OK}},
        '{ROW_BEAT, '{FUNC_QUERY, 16'sh7FFF, 8'h55, 1'b0}, 13'd0, 13'd0, 1'b0, '0},
        '{ROW_BEAT, '{FUNC_QUERY, 16'sh8000, 8'hAA, 1'b0}, 13'd0, 13'd0, 1'b0, '0},
        '{ROW_BEAT, '{FUNC_QUERY, 16'sh0000, 8'h00, 1'b1}, 13'd0, 13'd0, 1'b0, '0},
        '{ROW_CFG, '0, 13'd3, 13'd1, 1'b0, '0},
        '{ROW_BEAT, '{FUNC_QUERY, 16'sh0001, 8'h00, 1'b1}, 13'd0, 13'd0,
          1'b1, '{COST_SENTINEL, ST_OK}},
        '{ROW_BEAT, '{FUNC_QUERY, 16'sh0064, 8'h00, 1'b0}, 13'd0, 13'd0, 1'b0, '0},
        '{ROW_BEAT, '{FUNC_QUERY, 16'shFF9C, 8'h00, 1'b0}, 13'd0, 13'd0, 1'b0, '0},
        '{ROW_BEAT, '{FUNC_QUERY, 16'sh0005, 8'h00, 1'b1}, 13'd0, 13'd0, 1'b0, '0},
        '{ROW_CFG, '0, 13'd1, 13'd8191, 1'b0, '0},
        '{ROW_BEAT, '{FUNC_QUERY, 16'sh7FFF, 8'h00, 1'b1}, 13'd0, 13'd0,
          1'b1, '{31'd0, ST_OK}},
        '{ROW_BEAT, '{FUNC_QUERY, 16'sh8000, 8'h00, 1'b1}, 13'd0, 13'd0,
          1'b1, '{31'd65535, ST_OK}},
        '{ROW_CFG, '0, 13'd0, 13'd0, 1'b0, '0},
        '{ROW_BEAT, '{FUNC_QUERY, 16'shFFFF, 8'h00, 1'b0}, 13'd0, 13'd0, 1'b0, '0},
        '{ROW_BEAT, '{FUNC_QUERY, 16'sh0001, 8'h00, 1'b1}, 13'd0, 13'd0,
          1'b1, '{COST_SENTINEL, ST_EMPTY}}
    };

    // Predictor state: its own copy of the registers, the reference store and
    // the cost row kept between query beats.
    logic signed [SAMPLE_W-1:0] ref_copy [MAX_REF_LEN];
    logic [31:0]                row_cost [MAX_REF_LEN+1];
    int                         rows_taken;
    bit                         too_long;
    logic [LEN_W-1:0]           len_now;
    logic [BAND_W-1:0]          band_now;

    // Reference entries written so far; a query never reads one that was not.
    bit ref_written [MAX_REF_LEN];

    t_result pending_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int beats_sent;
    int loads_sent;
    int queries_sent;
    int reg_writes;
    int mismatch_count;
    int results_by_status [4];

    function automatic void clear_cost_row();
        foreach (row_cost[j]) row_cost[j] = SENTINEL_32;
        row_cost[0] = '0;
    endfunction

    // Applies one accepted beat to the predictor state. Returns 1 when the
    // beat produces a result, which is then left in r.
    function automatic bit predict_warp_distance(input t_beat b, output t_result r);
        logic [31:0] fresh [MAX_REF_LEN+1];
        logic [31:0] m;
        longint      total;
        int          lc;
        int          row;
        int          lo;
        int          hi;
        int          diff;
        lc = (len_now > MAX_REF_LEN) ? MAX_REF_LEN : int'(len_now);
        r = '0;
        if (b.func == FUNC_LOAD) begin
            ref_copy[b.ref_index] = b.sample;
            return 1'b0;
        end
        if (rows_taken >= MAX_QUERY_LEN) begin
            too_long = 1'b1;
        end else begin
            rows_taken++;
            row = rows_taken;
            lo = 1;
            hi = lc;
            if (band_now != 0) begin
                if (row - int'(band_now) > lo) lo = row - int'(band_now);
                if (row + int'(band_now) < hi) hi = row + int'(band_now);
            end
            foreach (fresh[j]) fresh[j] = SENTINEL_32;
            for (int j = lo; j <= hi; j++) begin
                diff = int'($signed(b.sample)) - int'($signed(ref_copy[j-1]));
                if (diff < 0) diff = -diff;
                // Cheapest of the cell above, above-left and to the left.
                m = row_cost[j];
                if (row_cost[j-1] < m) m = row_cost[j-1];
                if (fresh[j-1] < m) m = fresh[j-1];
                if (m >= SENTINEL_32) begin
                    fresh[j] = SENTINEL_32;
                end else begin
                    total = longint'(m) + longint'(diff);
                    fresh[j] = (total > longint'(SENTINEL_32)) ? SENTINEL_32 : total[31:0];
                end
            end
            row_cost = fresh;
        end
        if (!b.last) return 1'b0;
        if (lc == 0) begin
            r = '{COST_SENTINEL, ST_EMPTY};
        end else if (too_long) begin
            r = '{COST_SENTINEL, ST_OVERLONG};
        end else begin
            r = '{row_cost[lc][DIST_W-1:0], ST_OK};
        end
        clear_cost_row();
        rows_taken = 0;
        too_long = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Sends one beat, possibly after a random gap, and waits for it to be taken.
    // The valid line is left high on return so back-to-back beats stay seamless.
    task automatic send_beat(input t_beat b, input bit typed = 1'b0,
                             input t_result want = '0);
        int      gap;
        t_result r;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(300, 1) : $urandom_range(4, 1);
        end
        if (gap != 0) begin
            beat_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        beat_in.valid     <= 1'b1;
        beat_in.func      <= b.func;
        beat_in.sample    <= b.sample;
        beat_in.ref_index <= b.ref_index;
        beat_in.last      <= b.last;
        do @(posedge i_clk); while (!beat_in.ready);
        beats_sent++;
        if (b.func == FUNC_LOAD) begin
            loads_sent++;
            ref_written[b.ref_index] = 1'b1;
        end else begin
            queries_sent++;
        end
        if (predict_warp_distance(b, r)) pending_results.push_back(typed ? want : r);
    endtask

    // Holds the sender back until every expected result has come out, then
    // lets a query beat that produces no result finish its sweep.
    task automatic hold_until_drained();
        beat_in.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the reference length and then the band width, only while idle.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] len,
                                input logic [CFG_DATA_W-1:0] band);
        hold_until_drained();
        cfg_wr.valid <= 1'b1;
        cfg_wr.index <= CFG_REF_LENGTH;
        cfg_wr.data  <= len;
        do @(posedge i_clk); while (!cfg_wr.ready);
        len_now = len[LEN_W-1:0];
        cfg_wr.index <= CFG_BAND_WIDTH;
        cfg_wr.data  <= band;
        do @(posedge i_clk); while (!cfg_wr.ready);
        band_now = band[BAND_W-1:0];
        cfg_wr.valid <= 1'b0;
        reg_writes += 2;
    endtask

    // Loads every reference entry that the current length can reach and that
    // was never written, so no query ever reads an undefined sample.
    task automatic fill_reference();
        int lc;
        lc = (len_now > MAX_REF_LEN) ? MAX_REF_LEN : int'(len_now);
        for (int k = 0; k < lc; k++) begin
            if (!ref_written[k]) send_beat('{FUNC_LOAD, pick_sample(), 8'(k), 1'($urandom)});
        end
    endtask

    // Picks a new setting, mostly short references and narrow bands so the
    // band edges and unreachable final cells come up often. Lengths above the
    // maximum, stray upper data bits and the widest band are mixed in.
    task automatic reconfigure();
        logic [CFG_DATA_W-1:0] len;
        logic [CFG_DATA_W-1:0] band;
        case ($urandom_range(9))
            0:       len = 13'd0;
            1, 2:    len = 13'($urandom_range(64, 9));
            3:       len = 13'($urandom_range(256, 65));
            4:       len = {4'($urandom), 9'($urandom_range(511, 257))};
            default: len = 13'($urandom_range(8, 1));
        endcase
        if ($urandom_range(9) == 0) len[CFG_DATA_W-1:LEN_W] = 4'($urandom);
        case ($urandom_range(19))
            0:             band = 13'd8191;
            1:             band = 13'($urandom_range(8190, 65));
            2, 3, 4:       band = 13'($urandom_range(64, 5));
            5, 6, 7, 8, 9,
            10, 11:        band = 13'($urandom_range(4, 1));
            default:       band = 13'd0;
        endcase
        program_regs(len, band);
        fill_reference();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("run limit reached with %0d results still due", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // The receiver drops ready at random; with a zero rate it never stalls.
    always @(posedge i_clk) begin
        result_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Scoreboard: every result beat is matched against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_result seen;
        t_result due;
        if (i_rst_n && result_out.valid && result_out.ready) begin
            seen = '{result_out.distance, result_out.status};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: result with nothing due: distance %0d status %0d",
                             $realtime, seen.distance, seen.status);
                end
            end else begin
                due = pending_results.pop_front();
                results_by_status[due.status]++;
                if (seen.distance !== due.distance || seen.status !== due.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: expected distance %0d status %0d, got distance %0d status %0d",
                                 $realtime, due.distance, due.status, seen.distance, seen.status);
                    end
                end
            end
        end
    end

    initial begin
        int  qlen;
        int  random_start;
        int  progress;
        int  long_len;
        // Every input starts at a known value while reset is held.
        i_rst_n           = 1'b0;
        beat_in.valid     = 1'b0;
        beat_in.func      = FUNC_LOAD;
        beat_in.sample    = '0;
        beat_in.ref_index = '0;
        beat_in.last      = 1'b0;
        cfg_wr.valid      = 1'b0;
        cfg_wr.index      = CFG_REF_LENGTH;
        cfg_wr.data       = '0;
        result_out.ready  = 1'b0;
        send_idle_pct     = 21;
        recv_idle_pct     = 54;
        len_now           = '0;
        band_now          = '0;
        rows_taken        = 0;
        too_long          = 1'b0;
        foreach (ref_copy[k]) ref_copy[k] = '0;
        foreach (ref_written[k]) ref_written[k] = 1'b0;
        clear_cost_row();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_CFG) begin
                program_regs(plan[n].len, plan[n].band);
            end else begin
                send_beat(plan[n].beat, plan[n].typed, plan[n].want);
            end
        end

        // Random part: well-formed queries of random length and content, with
        // load beats sprinkled in as noise, an occasional register change in
        // the middle of a query, and now and then a full pause of the sender.
        // The idling pattern turns over each third: sender light and receiver
        // heavy, then the reverse, then no idling at all.
        random_start = beats_sent;
        while (beats_sent - random_start < RANDOM_BEATS) begin
            progress = beats_sent - random_start;
            if (progress < RANDOM_BEATS / 3) begin
                send_idle_pct = 21;
                recv_idle_pct = 54;
            end else if (progress < 2 * RANDOM_BEATS / 3) begin
                send_idle_pct = 54;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (progress == 0 || $urandom_range(3) == 0) reconfigure();
            qlen = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
            for (int s = 1; s <= qlen; s++) begin
                while ($urandom_range(99) < 25) begin
                    send_beat('{FUNC_LOAD, pick_sample(), 8'($urandom), 1'($urandom)});
                end
                if (s > 1 && $urandom_range(99) < 3) reconfigure();
                send_beat('{FUNC_QUERY, pick_sample(), 8'($urandom), s == qlen});
            end
            if ($urandom_range(9) == 0) hold_until_drained();
        end

        // One query longer than the block allows. Halfway through, both
        // registers change; the rows beyond the limit leave the row alone and
        // the answer is the too-long status.
        program_regs(13'd4, 13'd2);
        fill_reference();
        long_len = MAX_QUERY_LEN + 3;
        for (int s = 1; s <= long_len; s++) begin
            if (s == MAX_QUERY_LEN / 2) begin
                program_regs(13'd7, 13'd0);
                fill_reference();
            end
            send_beat('{FUNC_QUERY, pick_sample(), 8'($urandom), s == long_len});
        end

        hold_until_drained();
        $display("Sent %0d beats: %0d reference loads and %0d query samples, %0d register writes.",
                 beats_sent, loads_sent, queries_sent, reg_writes);
        $display("Checked distances: %0d ok, %0d empty reference, %0d over-long; %0d mismatches.",
                 results_by_status[ST_OK], results_by_status[ST_EMPTY],
                 results_by_status[ST_OVERLONG], mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
